[design/hebp_pkg.sv]
// shared types and constants of the huffman escape bit packer
// used by hebp_res_fifo and huffman_escape_bit_packer, depends on nothing

package hebp_pkg;

    localparam int IN_DATA_W  = 88;   // 85 payload bits padded to bytes
    localparam int OUT_DATA_W = 136;  // 134 payload bits padded to bytes
    localparam int IN_USER_W  = 2;
    localparam int OUT_USER_W = 3;
    localparam int WORD_W     = 32;
    localparam int TOTAL_W    = 38;
    localparam int LEN_W      = 6;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        KIND_WORD   = 2'd0,
        KIND_ESCAPE = 2'd1,
        KIND_SUMMARY = 2'd2,
        KIND_ERROR  = 2'd3
    } t_kind;

    // one result transaction in compact form; data holds word, escape value or bit total
    typedef struct packed {
        t_kind               kind;
        logic [TOTAL_W-1:0]  data;
        logic [WORD_W-1:0]   count;
        logic                last;
    } t_res;

endpackage

[design/huffman_escape_bit_packer.sv]
// top level of the huffman escape bit packer: code table memory, packing stage
// and result queue; depends on hebp_pkg and hebp_res_fifo
//
// Usage:
//   s_axis carries commands: tuser selects load, encode or flush. A load writes
//   one code table entry, an encode offsets a level, looks up its code (entry 0
//   as escape code for levels out of range) and packs it MSB first into 32-bit
//   words, a flush drains the partial word and reports the bit and escape counts.
//   m_axis carries results: tuser gives kind and error flag, tlast marks the final
//   result of a command.
//   Flow: an accepted encode or flush is registered in the packing stage, which
//   pushes its results into the result queue once it has room for two; m_axis reads
//   the queue. Throughput: one command per cycle while s_axis_tready is high; the
//   output side delivers one result per cycle, while encodes that give both an
//   escape and a word, and flushes with a partial word, push two. The single write
//   port of the code table takes loads, its read port encodes, one each per cycle.
//   Reset: a clearing pass of NUM_LEVELS cycles zeroes the code table, during
//   which s_axis_tready stays low; packer state and counters reset at once.
//   A stalled receiver fills the four-entry result queue, then the packing stage
//   holds its command and s_axis_tready drops until space frees up.

module huffman_escape_bit_packer #(
    parameter int NUM_LEVELS = 32768
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // entry_index, entry_code, entry_len, level, zero pad
    input  logic [hebp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // op
    input  logic [hebp_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // packed_word, escape_value, bit_total, escape_count, zero pad
    output logic [hebp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // kind, error
    output logic [hebp_pkg::OUT_USER_W-1:0] m_axis_tuser,
    output logic                            m_axis_tlast
);
    import hebp_pkg::*;

    localparam int AW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_LEVELS - 1);
    localparam int ENT_W = LEN_W + WORD_W;

    // input fields
    logic [14:0]        w_idx;
    logic [WORD_W-1:0]  w_in_code;
    logic [LEN_W-1:0]   w_in_len;
    logic [WORD_W-1:0]  w_level;
    t_op                w_op;

    logic               w_accept;
    logic [WORD_W-1:0]  w_q;
    logic               w_in_range;
    logic               w_load_ok;
    logic [LEN_W-1:0]   w_sat_len;

    // code table
    logic [ENT_W-1:0]   mem [NUM_LEVELS];
    logic [ENT_W-1:0]   r_rd;
    logic               w_mem_we;
    logic [AW-1:0]      w_mem_waddr;
    logic [ENT_W-1:0]   w_mem_wdata;
    logic               w_mem_re;
    logic [AW-1:0]      w_mem_raddr;

    logic               r_clr_busy;
    logic [AW-1:0]      r_clr_addr;

    // packing stage
    logic               r_s1_valid;
    t_op                r_s1_op;
    logic [WORD_W-1:0]  r_s1_q;
    logic               r_s1_esc;
    logic               w_s1_fire;

    logic [WORD_W-1:0]  r_acc, n_acc;
    logic [4:0]         r_pos, n_pos;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [WORD_W-1:0]  r_esc_cnt, n_esc_cnt;

    logic [LEN_W-1:0]   w_len;
    logic [WORD_W-1:0]  w_code;
    logic [WORD_W-1:0]  w_mask;
    logic [LEN_W-1:0]   w_sum;
    logic [LEN_W-1:0]   w_shamt;
    logic [63:0]        w_buf;

    logic [1:0]         w_push_cnt;
    t_res               w_res0, w_res1, w_out;
    logic               w_room2;
    logic               w_out_valid;

    assign w_idx     = s_axis_tdata[14:0];
    assign w_in_code = s_axis_tdata[46:15];
    assign w_in_len  = s_axis_tdata[52:47];
    assign w_level   = s_axis_tdata[84:53];
    assign w_op      = t_op'(s_axis_tuser);

    assign w_s1_fire     = r_s1_valid && w_room2;
    assign s_axis_tready = !r_clr_busy && (!r_s1_valid || w_s1_fire);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_q        = w_level + WORD_W'(NUM_LEVELS);
    assign w_in_range = (w_q != '0) && (w_q < WORD_W'(NUM_LEVELS));
    assign w_load_ok  = ({17'd0, w_idx} < WORD_W'(NUM_LEVELS));
    assign w_sat_len  = (w_in_len > LEN_W'(32)) ? LEN_W'(32) : w_in_len;

    // table port control: the clearing pass owns the write port after reset
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = r_clr_addr;
        w_mem_wdata = '0;
        if (r_clr_busy) begin
            w_mem_we = 1'b1;
        end else if (w_accept && w_op == OP_LOAD && w_load_ok) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = AW'({17'd0, w_idx});
            w_mem_wdata = {w_sat_len, w_in_code};
        end
        w_mem_re    = w_accept && (w_op == OP_ENCODE);
        w_mem_raddr = w_in_range ? w_q[AW-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_rd <= mem[w_mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == LAST_ADDR) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // stage 1 holds encodes and flushes; loads finish at the table write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= (w_op == OP_ENCODE) || (w_op == OP_FLUSH);
        end else if (w_s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_op  <= w_op;
            r_s1_q   <= w_q;
            r_s1_esc <= !w_in_range;
        end
    end

    assign w_len   = r_rd[ENT_W-1:WORD_W];
    assign w_mask  = (w_len >= LEN_W'(32)) ? '1 : ((WORD_W'(1) << w_len) - WORD_W'(1));
    assign w_code  = r_rd[WORD_W-1:0] & w_mask;
    assign w_sum   = LEN_W'(r_pos) + w_len;
    assign w_shamt = LEN_W'(0) - w_sum;   // 64 - sum, sum is never zero here
    assign w_buf   = {r_acc, 32'd0} | ({32'd0, w_code} << w_shamt);

    always_comb begin
        n_acc      = r_acc;
        n_pos      = r_pos;
        n_total    = r_total;
        n_esc_cnt  = r_esc_cnt;
        w_push_cnt = 2'd0;
        w_res0     = '{kind: KIND_WORD, data: '0, count: '0, last: 1'b0};
        w_res1     = '{kind: KIND_WORD, data: '0, count: '0, last: 1'b0};
        if (w_s1_fire) begin
            unique case (r_s1_op)
                OP_ENCODE: begin
                    if (w_len == '0) begin
                        w_push_cnt  = 2'd1;
                        w_res0.kind = KIND_ERROR;
                        w_res0.last = 1'b1;
                    end else begin
                        n_total = r_total + TOTAL_W'(w_len);
                        if (w_sum >= LEN_W'(32)) begin
                            n_acc = w_buf[31:0];
                            n_pos = 5'(w_sum - LEN_W'(32));
                        end else begin
                            n_acc = w_buf[63:32];
                            n_pos = w_sum[4:0];
                        end
                        // escape result goes ahead of a word filled by the same symbol
                        if (r_s1_esc) begin
                            n_esc_cnt   = r_esc_cnt + WORD_W'(1);
                            w_res0.kind = KIND_ESCAPE;
                            w_res0.data = TOTAL_W'(r_s1_q);
                            if (w_sum >= LEN_W'(32)) begin
                                w_push_cnt  = 2'd2;
                                w_res1.data = TOTAL_W'(w_buf[63:32]);
                                w_res1.last = 1'b1;
                            end else begin
                                w_push_cnt  = 2'd1;
                                w_res0.last = 1'b1;
                            end
                        end else if (w_sum >= LEN_W'(32)) begin
                            w_push_cnt  = 2'd1;
                            w_res0.data = TOTAL_W'(w_buf[63:32]);
                            w_res0.last = 1'b1;
                        end
                    end
                end
                OP_FLUSH: begin
                    n_acc     = '0;
                    n_pos     = '0;
                    n_total   = '0;
                    n_esc_cnt = '0;
                    if (r_pos != '0) begin
                        w_push_cnt   = 2'd2;
                        w_res0.data  = TOTAL_W'(r_acc);
                        w_res1.kind  = KIND_SUMMARY;
                        w_res1.data  = r_total;
                        w_res1.count = r_esc_cnt;
                        w_res1.last  = 1'b1;
                    end else begin
                        w_push_cnt   = 2'd1;
                        w_res0.kind  = KIND_SUMMARY;
                        w_res0.data  = r_total;
                        w_res0.count = r_esc_cnt;
                        w_res0.last  = 1'b1;
                    end
                end
                default: begin
                    w_push_cnt = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_pos     <= '0;
            r_total   <= '0;
            r_esc_cnt <= '0;
        end else begin
            r_acc     <= n_acc;
            r_pos     <= n_pos;
            r_total   <= n_total;
            r_esc_cnt <= n_esc_cnt;
        end
    end

    hebp_res_fifo u_res_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_push_cnt),
        .i_res0     (w_res0),
        .i_res1     (w_res1),
        .o_room2    (w_room2),
        .o_valid    (w_out_valid),
        .o_res      (w_out),
        .i_pop      (m_axis_tready)
    );

    // spread the compact result over the output fields by kind
    always_comb begin
        m_axis_tvalid = w_out_valid;
        m_axis_tlast  = w_out.last;
        m_axis_tuser  = {(w_out.kind == KIND_ERROR), w_out.kind};
        m_axis_tdata  = '0;
        unique case (w_out.kind)
            KIND_WORD:    m_axis_tdata[31:0]  = w_out.data[31:0];
            KIND_ESCAPE:  m_axis_tdata[63:32] = w_out.data[31:0];
            KIND_SUMMARY: begin
                m_axis_tdata[101:64]  = w_out.data;
                m_axis_tdata[133:102] = w_out.count;
            end
            KIND_ERROR:   m_axis_tdata = '0;
            default:      m_axis_tdata = '0;
        endcase
    end

    // no command is taken while the table is being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !s_axis_tready)
        else $error("command accepted during table clearing");

    // a stalled packing stage keeps its command
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_fire) |=> (r_s1_valid && $stable(r_s1_op) && $stable(r_s1_q)))
        else $error("packing stage lost a stalled command");

    // a flush leaves the packer and counters empty
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_fire && r_s1_op == OP_FLUSH) |=> (r_pos == '0 && r_total == '0
            && r_esc_cnt == '0))
        else $error("flush did not clear packer state");

    // an error result is always the only and final result of its command
    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_out.kind == KIND_ERROR) |-> m_axis_tlast)
        else $error("error result without tlast");

endmodule

[design/hebp_res_fifo.sv]
// result queue of the huffman escape bit packer: takes up to two results a cycle,
// gives one a cycle when popped; depends on hebp_pkg

module hebp_res_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [1:0]    i_push_cnt,
    input  hebp_pkg::t_res i_res0,
    input  hebp_pkg::t_res i_res1,
    output logic          o_room2,
    output logic          o_valid,
    output hebp_pkg::t_res o_res,
    input  logic          i_pop
);
    import hebp_pkg::*;

    t_res               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_AW:0]   r_count, n_count;
    logic               w_pop;

    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rd_ptr];
    assign o_room2 = (r_count <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_AW'(i_push_cnt);
        n_rd_ptr = r_rd_ptr + FIFO_AW'(w_pop);
        n_count  = r_count + (FIFO_AW+1)'(i_push_cnt) - (FIFO_AW+1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wr_ptr + FIFO_AW'(1)] <= i_res1;
        end
    end

endmodule

[test/huffman_escape_bit_packer_tb.sv]
// self-checking testbench of huffman_escape_bit_packer: drives load, encode and flush
// commands on s_axis and checks every m_axis transaction against an internal predictor
// depends on hebp_pkg and the design files under design

module huffman_escape_bit_packer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hebp_pkg::*;

    localparam int          LEVELS         = 32768;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    localparam int          RANDOM_CMDS    = 1600;
    localparam int          POOL_TOP       = 40;
    localparam int          CALM_CMDS      = 200;
    localparam int          HOLD_AT        = 300;
    localparam int          HOLD_CYCLES    = 64;
    localparam int          DRAIN_CYCLES   = 10;
    localparam int          QUIET_LIMIT    = 150000;
    localparam int          MAX_REPORTS    = 20;

    typedef struct {
        logic [1:0]  op;
        logic [14:0] index;
        logic [31:0] code;
        logic [5:0]  len;
        logic [31:0] level;
    } t_cmd;

    typedef struct {
        t_kind        kind;
        logic [31:0]  word;
        logic [31:0]  esc_val;
        logic [37:0]  bits;
        logic [31:0]  escapes;
        logic         err;
        logic         last;
    } t_exp;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  m_axis_tlast;

    huffman_escape_bit_packer #(
        .NUM_LEVELS(LEVELS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        // entry_index, entry_code, entry_len, level, zero pad
        .s_axis_tdata(s_axis_tdata),
        // op
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        // packed_word, escape_value, bit_total, escape_count, zero pad
        .m_axis_tdata(m_axis_tdata),
        // kind, error
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    // predictor state
    logic [31:0] code_of [LEVELS];
    logic [5:0]  len_of [LEVELS];
    logic [31:0] acc_word;
    logic [5:0]  acc_fill;
    logic [37:0] bits_since_flush;
    logic [31:0] escapes_since_flush;

    t_cmd        pending_cmds[$];
    t_exp        expected_results[$];
    t_cmd        drv_cmd;
    int unsigned total_cmds;
    int unsigned cmds_offered = 0;
    int unsigned cmds_accepted = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    int unsigned kind_seen [4] = '{0, 0, 0, 0};
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    bit          calm;

    assign calm = (cmds_offered + CALM_CMDS >= total_cmds);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic add_cmd(input logic [1:0] op, input logic [14:0] index,
                           input logic [31:0] code, input logic [5:0] len,
                           input logic [31:0] level);
        t_cmd c;
        c.op = op;
        c.index = index;
        c.code = code;
        c.len = len;
        c.level = level;
        pending_cmds.push_back(c);
    endtask

    task automatic add_encode(input logic [31:0] level);
        add_cmd(OP_ENCODE, 15'($urandom), $urandom, 6'($urandom), level);
    endtask

    task automatic add_load(input logic [14:0] index, input logic [31:0] code,
                            input logic [5:0] len);
        add_cmd(OP_LOAD, index, code, len, $urandom);
    endtask

    // random level within the field range, mostly out of table range
    function automatic logic [31:0] any_level();
        logic [31:0] v;
        v = $urandom;
        if ($signed(v) > 32'sd2147450879)
            v = v - 32'd32768;
        return v;
    endfunction

    task automatic push_result(input t_kind kind, input logic [31:0] word,
                               input logic [31:0] esc_val, input logic [37:0] bits,
                               input logic [31:0] escapes, input logic err,
                               input logic last);
        t_exp r;
        r.kind = kind;
        r.word = word;
        r.esc_val = esc_val;
        r.bits = bits;
        r.escapes = escapes;
        r.err = err;
        r.last = last;
        expected_results.push_back(r);
    endtask

    // works out the results of one accepted command and updates the packer copy
    task automatic predict_packer(input t_cmd c);
        logic [31:0] q;
        logic [14:0] idx;
        logic [5:0]  len;
        logic [31:0] code;
        logic [63:0] joined;
        logic [6:0]  sum;
        bit          in_range;
        bit          word_full;
        case (c.op)
            OP_LOAD: begin
                code_of[c.index] = c.code;
                len_of[c.index] = (c.len > 6'd32) ? 6'd32 : c.len;
            end
            OP_ENCODE: begin
                q = c.level + 32'd32768;
                in_range = !q[31] && q != 32'd0 && q < LEVELS;
                idx = in_range ? q[14:0] : 15'd0;
                len = len_of[idx];
                if (len == 6'd0) begin
                    push_result(KIND_ERROR, '0, '0, '0, '0, 1'b1, 1'b1);
                end else begin
                    code = code_of[idx];
                    if (len < 6'd32)
                        code = code & ((32'd1 << len) - 32'd1);
                    sum = acc_fill + len;
                    joined = {acc_word, 32'd0} | ({32'd0, code} << (7'd64 - sum));
                    word_full = (sum >= 7'd32);
                    if (!in_range) begin
                        push_result(KIND_ESCAPE, '0, q, '0, '0, 1'b0, !word_full);
                        escapes_since_flush = escapes_since_flush + 32'd1;
                    end
                    if (word_full) begin
                        push_result(KIND_WORD, joined[63:32], '0, '0, '0, 1'b0, 1'b1);
                        acc_word = joined[31:0];
                        acc_fill = 6'(sum - 7'd32);
                    end else begin
                        acc_word = joined[63:32];
                        acc_fill = sum[5:0];
                    end
                    bits_since_flush = bits_since_flush + 38'(len);
                end
            end
            OP_FLUSH: begin
                if (acc_fill != 6'd0)
                    push_result(KIND_WORD, acc_word, '0, '0, '0, 1'b0, 1'b0);
                push_result(KIND_SUMMARY, '0, '0, bits_since_flush, escapes_since_flush,
                            1'b0, 1'b1);
                acc_word = '0;
                acc_fill = '0;
                bits_since_flush = '0;
                escapes_since_flush = '0;
            end
            default: begin
            end
        endcase
    endtask

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%t mismatch in %s: expected %0h, actual %0h",
                         $realtime, name, exp_v, act_v);
        end
    endfunction

    task automatic check_result();
        t_exp r;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%t unexpected transaction: expected none, actual tuser %0h tdata %0h",
                         $realtime, m_axis_tuser, m_axis_tdata);
        end else begin
            r = expected_results.pop_front();
            kind_seen[r.kind]++;
            check_field("kind", 64'(r.kind), 64'(m_axis_tuser[1:0]));
            check_field("packed_word", 64'(r.word), 64'(m_axis_tdata[31:0]));
            check_field("escape_value", 64'(r.esc_val), 64'(m_axis_tdata[63:32]));
            check_field("bit_total", 64'(r.bits), 64'(m_axis_tdata[101:64]));
            check_field("escape_count", 64'(r.escapes), 64'(m_axis_tdata[133:102]));
            check_field("error", 64'(r.err), 64'(m_axis_tuser[2]));
            check_field("last", 64'(r.last), 64'(m_axis_tlast));
        end
        results_checked++;
    endtask

    // monitor, predictor and watchdog, all on the sampling edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (s_axis_tvalid && s_axis_tready) begin
                predict_packer(drv_cmd);
                cmds_accepted++;
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%t no transaction for %0d cycles", $realtime, quiet_cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // command driver: holds the current command until its transaction
    always @(negedge i_clk) begin
        if (i_rst_n && !(s_axis_tvalid && cmds_accepted != cmds_offered)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_cmds.size() > 0 && !calm && $urandom_range(0, 4) == 0) begin
                send_gap = $urandom_range(0, 3);
                s_axis_tvalid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                drv_cmd = pending_cmds.pop_front();
                s_axis_tdata <= {3'd0, drv_cmd.level, drv_cmd.len, drv_cmd.code, drv_cmd.index};
                s_axis_tuser <= drv_cmd.op;
                s_axis_tvalid <= 1'b1;
                cmds_offered++;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls plus one long hold-off to back up the result queue
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && results_checked >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        int unsigned pick;
        int unsigned lvl;

        for (int i = 0; i < LEVELS; i++) begin
            code_of[i] = '0;
            len_of[i] = '0;
        end
        acc_word = '0;
        acc_fill = '0;
        bits_since_flush = '0;
        escapes_since_flush = '0;

        // directed: empty table, saturation, masking, range edges, unused op
        add_encode(32'd5);
        add_encode(32'hFFFF_FFFF);
        add_cmd(OP_FLUSH, '0, '0, '0, '0);
        add_load(15'd0, 32'hFFFF_FFFF, 6'd63);
        add_load(15'd32767, 32'hFFFF_FFFF, 6'd3);
        add_load(15'd1, 32'h0000_0005, 6'd1);
        add_encode(-32'sd32767);
        add_encode(-32'sd1);
        add_encode(32'd0);
        add_encode(-32'sd32768);
        add_encode(32'd2147450879);
        add_encode(32'h8000_0000);
        add_cmd(OP_UNUSED, 15'h7FFF, 32'hFFFF_FFFF, 6'h3F, 32'hFFFF_FFFF);
        add_load(15'd32767, 32'hA5A5_A5A5, 6'd0);
        add_encode(-32'sd1);
        add_load(15'd16384, 32'h1234_5678, 6'd32);
        add_encode(-32'sd16384);
        add_cmd(OP_FLUSH, '0, '0, '0, '0);
        add_load(15'd0, 32'h0000_0000, 6'd0);
        add_encode(32'd100);
        add_load(15'd0, 32'h0000_005B, 6'd7);
        add_encode(32'd100);
        add_cmd(OP_FLUSH, '0, '0, '0, '0);

        // a small pool of live entries so most encodes hit a loaded code
        for (int i = 1; i <= POOL_TOP; i++)
            add_load(15'(i), $urandom, 6'($urandom_range(1, 32)));

        for (int i = 0; i < RANDOM_CMDS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                if ($urandom_range(0, 9) < 7)
                    add_load(15'($urandom_range(0, POOL_TOP)), $urandom,
                             ($urandom_range(0, 19) == 0) ? 6'($urandom_range(0, 63))
                                                          : 6'($urandom_range(1, 32)));
                else
                    add_load(15'($urandom), $urandom, 6'($urandom_range(0, 63)));
            end else if (pick < 88) begin
                lvl = $urandom_range(0, 99);
                if (lvl < 60)
                    add_encode($urandom_range(1, POOL_TOP) - 32768);
                else if (lvl < 75)
                    add_encode($urandom_range(1, 32767) - 32768);
                else
                    add_encode(any_level());
            end else if (pick < 97) begin
                add_cmd(OP_FLUSH, 15'($urandom), $urandom, 6'($urandom), $urandom);
            end else begin
                add_cmd(OP_UNUSED, 15'($urandom), $urandom, 6'($urandom), $urandom);
            end
        end
        add_cmd(OP_FLUSH, '0, '0, '0, '0);
        total_cmds = pending_cmds.size();

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmds_accepted != total_cmds)
            @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d commands and %0d result transactions:", cmds_accepted,
                 results_checked);
        $display("  %0d words, %0d escapes, %0d summaries, %0d errors, long receiver hold %0s",
                 kind_seen[KIND_WORD], kind_seen[KIND_ESCAPE], kind_seen[KIND_SUMMARY],
                 kind_seen[KIND_ERROR], hold_done ? "done" : "missed");
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[files.f]
design/hebp_pkg.sv
design/hebp_res_fifo.sv
design/huffman_escape_bit_packer.sv
test/huffman_escape_bit_packer_tb.sv
